// ----- hdl/swps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swps_pkg
// Shared types and constants for the stop-and-wait packet sender.
// ----------------------------------------------------------------------------
package swps_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 16;

  // payload field widths (fixed by the stream format)
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned POS_W   = 4;

  // slave tdata: data_byte, response_nack, padded to 16 bits
  localparam int unsigned S_TDATA_W = 16;
  // master tdata: packet_type, payload_count, sum_value, byte_position,
  // payload_byte, padded to 32 bits
  localparam int unsigned M_TDATA_W = 32;

  // tuser codes on the slave side
  localparam logic OPC_BYTE = 1'b0;
  localparam logic OPC_RESP = 1'b1;

  // tuser codes on the master side
  localparam logic ST_SENT    = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_EMIT   = 4'b0100,
    S_REFUSE = 4'b1000
  } state_e;

  typedef struct packed {
    logic take_byte;   // store byte, bump count and sum
    logic arm;         // packet closed: wait for reply, latch final mark
    logic clear;       // ACK: empty the store
    logic idx_clr;     // rewind readout index
    logic idx_inc;
    logic fetch;       // read store at readout index
    logic load_pkt;    // load output word from fetched byte
    logic load_ref;    // load refused word
  } cmd_t;

  typedef struct packed {
    logic awaiting;    // packet out, reply pending
    logic near_full;   // next stored byte fills the store
    logic idx_last;    // readout index is on the last stored byte
  } sts_t;

endpackage

// ----- hdl/stop_and_wait_packet_sender_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_packet_sender_unit
// Buffers message bytes into a packet with an additive checksum, sends it
// byte by byte and resends on NACK until ACK.
//
//   channel  dir  tdata                                     tuser    tlast
//   s_axis   in   [7:0] data_byte, [8] response_nack        opcode   final_byte
//   m_axis   out  [0] type, [5:1] count, [17:6] sum,        status   packet_end
//                 [21:18] position, [29:22] payload byte
//
// A message byte or a reply is taken only while the sequencer idles.
// Each packet byte goes out by a store read, then the load of the output
// register; s_axis_tready stays low until the last byte of a packet is
// loaded. A refused word is loaded once the output is free.
// No clearing pass after reset. m_axis_tready low holds the output word and
// stalls the readout.
// ----------------------------------------------------------------------------
module stop_and_wait_packet_sender_unit
  import swps_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte, [8] response_nack
  input  logic                 s_axis_tuser,  // opcode
  input  logic                 s_axis_tlast,  // final_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [0] packet_type, [5:1] payload_count,
                                              // [17:6] sum_value, [21:18] byte_position,
                                              // [29:22] payload_byte
  output logic                 m_axis_tuser,  // status
  output logic                 m_axis_tlast   // packet_end
);

  cmd_t cmd;
  sts_t sts;

  swps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .final_i     (s_axis_tlast),
    .nack_i      (s_axis_tdata[BYTE_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swps_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .byte_i     (s_axis_tdata[BYTE_W-1:0]),
    .final_i    (s_axis_tlast),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- hdl/swps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swps_ctrl
// Sequencer: decodes accepted words, walks the packet readout and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module swps_ctrl
  import swps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic opcode_i,
  input  logic final_i,
  input  logic nack_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   acc, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign acc         = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (opcode_i == OPC_BYTE) begin
            if (sts_i.awaiting) begin
              state_d = S_REFUSE;
            end else begin
              cmd_o.take_byte = 1'b1;
              if (sts_i.near_full || final_i) begin
                cmd_o.arm     = 1'b1;
                cmd_o.idx_clr = 1'b1;
                state_d       = S_FETCH;
              end
            end
          end else begin
            if (!sts_i.awaiting) begin
              state_d = S_REFUSE;
            end else if (nack_i) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_FETCH;
            end else begin
              cmd_o.clear = 1'b1;
            end
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_pkt = 1'b1;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_FETCH;
          end
        end
      end
      S_REFUSE: begin
        if (out_free) begin
          cmd_o.load_ref = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_pkt || cmd_o.load_ref) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/swps_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swps_dpath
// Packet store, fill count, running sum, reply flags, readout index and the
// output word register.
// ----------------------------------------------------------------------------
module swps_dpath
  import swps_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [BYTE_W-1:0]    byte_i,
  input  logic                 final_i,
  output logic                 out_user_o,
  output logic                 out_last_o,
  output logic [M_TDATA_W-1:0] out_data_o
);

  localparam int unsigned CW = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(PAYLOAD_BYTES);
  localparam int unsigned PAD_W = M_TDATA_W - 1 - COUNT_W - SUM_W - POS_W - BYTE_W;

  logic [BYTE_W-1:0] store_mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0] rd_q;

  logic [CW-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             awaiting_q, awaiting_d;
  logic             final_q, final_d;
  logic [IW-1:0]    idx_q, idx_d;

  logic                 ouser_q, olast_q;
  logic [M_TDATA_W-1:0] odata_q;

  logic                 has_room;
  logic [CW-1:0]        idx_ext;
  logic [CW+COUNT_W-1:0] cnt_wide;
  logic [IW+POS_W-1:0]  pos_wide;

  assign has_room = (fill_q < FULL_CNT);
  assign idx_ext  = CW'(idx_q);
  assign cnt_wide = {{COUNT_W{1'b0}}, fill_q};
  assign pos_wide = {{POS_W{1'b0}}, idx_q};

  assign sts_o.awaiting  = awaiting_q;
  assign sts_o.near_full = (fill_q >= FULL_CNT - CW'(1));
  assign sts_o.idx_last  = (idx_ext == fill_q - CW'(1));

  always_comb begin
    fill_d     = fill_q;
    sum_d      = sum_q;
    awaiting_d = awaiting_q;
    final_d    = final_q;
    idx_d      = idx_q;
    if (cmd_i.take_byte && has_room) begin
      fill_d = fill_q + CW'(1);
      sum_d  = sum_q + SUM_W'(byte_i);
    end
    if (cmd_i.arm) begin
      awaiting_d = 1'b1;
      final_d    = final_i;
    end
    if (cmd_i.clear) begin
      awaiting_d = 1'b0;
      final_d    = 1'b0;
      fill_d     = '0;
      sum_d      = '0;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      sum_q      <= '0;
      awaiting_q <= 1'b0;
      final_q    <= 1'b0;
      idx_q      <= '0;
    end else begin
      fill_q     <= fill_d;
      sum_q      <= sum_d;
      awaiting_q <= awaiting_d;
      final_q    <= final_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && has_room) begin
      store_mem[fill_q[IW-1:0]] <= byte_i;
    end
    if (cmd_i.fetch) begin
      rd_q <= store_mem[idx_q];
    end
  end

  // output word; payload only, valid lives in the sequencer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pkt) begin
      ouser_q <= ST_SENT;
      olast_q <= sts_o.idx_last;
      odata_q <= {{PAD_W{1'b0}}, rd_q, pos_wide[POS_W-1:0], sum_q,
                  cnt_wide[COUNT_W-1:0], final_q};
    end else if (cmd_i.load_ref) begin
      ouser_q <= ST_REFUSED;
      olast_q <= 1'b0;
      odata_q <= '0;
    end
  end

  assign out_user_o = ouser_q;
  assign out_last_o = olast_q;
  assign out_data_o = odata_q;

endmodule

// ----- hdl/swps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swps_checker
// Port-level checks on the packet sender, bound to the top level.
// ----------------------------------------------------------------------------
module swps_checker
  import swps_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 m_axis_tlast
);

  localparam int unsigned SUM_LO = 1 + COUNT_W;

  logic             mid_run_q;
  logic [SUM_W-1:0] run_sum_q;
  logic             out_acc;

  assign out_acc = m_axis_tvalid & m_axis_tready;

  // remembers the checksum of a packet whose run is not finished yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_run_q <= 1'b0;
      run_sum_q <= '0;
    end else if (out_acc) begin
      mid_run_q <= (m_axis_tuser == ST_SENT) & ~m_axis_tlast;
      run_sum_q <= m_axis_tdata[SUM_LO +: SUM_W];
    end
  end

  // flops may be unknown before the first edge in reset, so check valid only after reset is sampled
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_REFUSED) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("refused word carries packet fields");

  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && mid_run_q) |->
      (m_axis_tuser == ST_SENT && m_axis_tdata[SUM_LO +: SUM_W] == run_sum_q))
    else $error("packet run broken or checksum changed mid run");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

endmodule

bind stop_and_wait_packet_sender_unit swps_checker u_swps_checker (.*);
